// File: rtl/vrra_pkg.sv
// vrra_pkg: shared types and constants of the variable record ring allocator
// no dependencies; used by the core and its checker
`default_nettype none

package vrra_pkg;

  localparam int PTR_W     = 15;
  localparam int ENTRY_W   = 14;
  localparam int SIZE_W    = 7;
  localparam int TYPE_W    = 3;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_RING_BYTES            = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_DURATION         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_DURATION_COLORED = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_INSTANT          = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_COUNTER          = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_LINK             = 3'd5;

  localparam logic [TYPE_W-1:0] REC_EMPTY            = 3'd0;
  localparam logic [TYPE_W-1:0] REC_DURATION         = 3'd1;
  localparam logic [TYPE_W-1:0] REC_DURATION_COLORED = 3'd2;
  localparam logic [TYPE_W-1:0] REC_INSTANT          = 3'd3;
  localparam logic [TYPE_W-1:0] REC_COUNTER          = 3'd4;
  localparam logic [TYPE_W-1:0] REC_LINK             = 3'd5;

  localparam logic [PTR_W-1:0]  RING_BYTES_RESET            = 15'd16384;
  localparam logic [SIZE_W-1:0] SIZE_DURATION_RESET         = 7'd16;
  localparam logic [SIZE_W-1:0] SIZE_DURATION_COLORED_RESET = 7'd20;
  localparam logic [SIZE_W-1:0] SIZE_INSTANT_RESET          = 7'd16;
  localparam logic [SIZE_W-1:0] SIZE_COUNTER_RESET          = 7'd16;
  localparam logic [SIZE_W-1:0] SIZE_LINK_RESET             = 7'd12;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_TAIL,
    ST_WALK_ADDR,
    ST_WALK_STEP,
    ST_HEAD,
    ST_BODY,
    ST_OUT
  } state_t;

endpackage

`default_nettype wire

// File: rtl/variable_record_ring_allocator_core.sv
// variable_record_ring_allocator_core: overwriting byte ring allocator for
// variable-size trace records; uses vrra_pkg
// Each request with a record type of 1 to 5 is accepted in ST_IDLE; it then
// marks the tail empty from the next offset to the ring end when the record
// wraps, walks the overwritten record headers in the type memory (one memory
// read per cycle), writes the header, clears the size - 1 body entries (one
// memory write per cycle) and loads the result register once it is free;
// an unknown type is accepted and gives no result.
// The result register lets the next request be accepted while a result waits.
// After reset every entry of the type memory is cleared, one entry per cycle,
// with in_stall high; configuration writes are taken at any time.
`default_nettype none

module variable_record_ring_allocator_core #(
  parameter int RING_DEPTH_BYTES = 16384
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             in_valid,
  output logic                            in_stall,
  input  wire  [vrra_pkg::TYPE_W-1:0]     in_record_type,
  output logic                            out_valid,
  input  wire                             out_stall,
  output logic [vrra_pkg::ENTRY_W-1:0]    out_entry_offset,
  output logic [vrra_pkg::PTR_W-1:0]      out_oldest_offset,
  output logic [vrra_pkg::PTR_W-1:0]      out_next_offset,
  input  wire                             cfg_valid,
  output logic                            cfg_ready,
  input  wire  [vrra_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire  [vrra_pkg::PTR_W-1:0]      cfg_wdata
);

  localparam int ADDR_W = $clog2(RING_DEPTH_BYTES);
  localparam logic [31:0] DEPTH_32 = 32'(RING_DEPTH_BYTES);
  localparam logic [ADDR_W-1:0] INIT_LAST = ADDR_W'(RING_DEPTH_BYTES - 1);

  localparam int PW = vrra_pkg::PTR_W;
  localparam int SW = vrra_pkg::SIZE_W;
  localparam int TW = vrra_pkg::TYPE_W;

  function automatic logic [ADDR_W-1:0] to_addr(input logic [PW-1:0] p);
    logic [31:0] w;
    w = {17'b0, p};
    return w[ADDR_W-1:0];
  endfunction

  function automatic logic [SW-1:0] sat_size(input logic [SW-1:0] raw,
                                             input logic [PW-1:0] ring);
    logic [SW-1:0] s;
    s = (raw == '0) ? 7'd1 : raw;
    if ({8'b0, s} > ring) s = ring[SW-1:0];
    return s;
  endfunction

  // configuration registers
  logic [PW-1:0] ring_bytes_r;
  logic [SW-1:0] size_dur_r, size_dur_col_r, size_inst_r, size_cnt_r, size_link_r;

  // control and datapath registers
  vrra_pkg::state_t state_r, state_nxt;
  logic [PW-1:0]     oldest_r, oldest_nxt;
  logic [PW-1:0]     next_r, next_nxt;
  logic [PW-1:0]     entry_r, entry_nxt;
  logic [PW-1:0]     end_r, end_nxt;
  logic [PW:0]       start_r, start_nxt;
  logic [PW-1:0]     clr_r, clr_nxt;
  logic [TW-1:0]     type_r, type_nxt;
  logic [ADDR_W-1:0] init_r, init_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [vrra_pkg::ENTRY_W-1:0] out_entry_r;
  logic [PW-1:0]     out_oldest_r, out_next_r;

  // type memory
  logic [TW-1:0]     type_mem [RING_DEPTH_BYTES];
  logic [TW-1:0]     rdata_r;
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [TW-1:0]     mem_wdata;

  logic [PW-1:0] ring_use;
  logic [SW-1:0] size_sat [8];
  logic [SW-1:0] in_size, walk_size;
  logic          in_acc, go, wrap;
  logic [PW:0]   step_sum;
  logic          start_in_range, step_in_range;
  logic          out_load;

  // ring size in use, saturated to 1..RING_DEPTH_BYTES
  always_comb begin
    if (ring_bytes_r == '0) begin
      ring_use = 15'd1;
    end else if ({17'b0, ring_bytes_r} > DEPTH_32) begin
      ring_use = DEPTH_32[PW-1:0];
    end else begin
      ring_use = ring_bytes_r;
    end
  end

  always_comb begin
    for (int k = 0; k < 8; k++) size_sat[k] = '0;
    size_sat[vrra_pkg::REC_DURATION]         = sat_size(size_dur_r, ring_use);
    size_sat[vrra_pkg::REC_DURATION_COLORED] = sat_size(size_dur_col_r, ring_use);
    size_sat[vrra_pkg::REC_INSTANT]          = sat_size(size_inst_r, ring_use);
    size_sat[vrra_pkg::REC_COUNTER]          = sat_size(size_cnt_r, ring_use);
    size_sat[vrra_pkg::REC_LINK]             = sat_size(size_link_r, ring_use);
  end

  assign in_size   = size_sat[in_record_type];
  assign walk_size = size_sat[rdata_r];
  assign in_acc    = in_valid && (state_r == vrra_pkg::ST_IDLE);
  assign go        = in_acc && (in_size != '0);
  assign wrap      = (next_r > ring_use) || ((ring_use - next_r) < {8'b0, in_size});

  assign step_sum       = start_r + {9'b0, walk_size};
  assign start_in_range = (start_r >= {1'b0, entry_r}) && (start_r < {1'b0, end_r});
  assign step_in_range  = (step_sum >= {1'b0, entry_r}) && (step_sum < {1'b0, end_r});
  assign out_load       = !out_valid_r || !out_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      vrra_pkg::ST_INIT: begin
        if (init_r == INIT_LAST) state_nxt = vrra_pkg::ST_IDLE;
      end
      vrra_pkg::ST_IDLE: begin
        if (go) begin
          if (wrap && (next_r < ring_use)) state_nxt = vrra_pkg::ST_TAIL;
          else state_nxt = vrra_pkg::ST_WALK_ADDR;
        end
      end
      vrra_pkg::ST_TAIL: begin
        if (clr_r + 15'd1 == ring_use) state_nxt = vrra_pkg::ST_WALK_ADDR;
      end
      vrra_pkg::ST_WALK_ADDR: begin
        if (start_in_range) state_nxt = vrra_pkg::ST_WALK_STEP;
        else state_nxt = vrra_pkg::ST_HEAD;
      end
      vrra_pkg::ST_WALK_STEP: begin
        if (walk_size == '0 || !step_in_range) state_nxt = vrra_pkg::ST_HEAD;
      end
      vrra_pkg::ST_HEAD: begin
        if (entry_r + 15'd1 < end_r) state_nxt = vrra_pkg::ST_BODY;
        else state_nxt = vrra_pkg::ST_OUT;
      end
      vrra_pkg::ST_BODY: begin
        if (clr_r + 15'd1 == end_r) state_nxt = vrra_pkg::ST_OUT;
      end
      vrra_pkg::ST_OUT: begin
        if (out_load) state_nxt = vrra_pkg::ST_IDLE;
      end
      default: state_nxt = vrra_pkg::ST_INIT;
    endcase
  end

  // state machine outputs: handshake and memory ports
  always_comb begin
    in_stall  = (state_r != vrra_pkg::ST_IDLE);
    mem_we    = 1'b0;
    mem_waddr = init_r;
    mem_wdata = vrra_pkg::REC_EMPTY;
    mem_re    = 1'b0;
    mem_raddr = to_addr(start_r[PW-1:0]);
    unique case (state_r) inside
      vrra_pkg::ST_INIT: begin
        mem_we = 1'b1;
      end
      vrra_pkg::ST_TAIL, vrra_pkg::ST_BODY: begin
        mem_we    = 1'b1;
        mem_waddr = to_addr(clr_r);
      end
      vrra_pkg::ST_WALK_ADDR: begin
        mem_re = start_in_range;
      end
      vrra_pkg::ST_WALK_STEP: begin
        mem_re    = (walk_size != '0) && step_in_range;
        mem_raddr = to_addr(step_sum[PW-1:0]);
      end
      vrra_pkg::ST_HEAD: begin
        mem_we    = 1'b1;
        mem_waddr = to_addr(entry_r);
        mem_wdata = type_r;
      end
      default: begin
      end
    endcase
  end

  // datapath next values
  always_comb begin
    oldest_nxt    = oldest_r;
    next_nxt      = next_r;
    entry_nxt     = entry_r;
    end_nxt       = end_r;
    start_nxt     = start_r;
    clr_nxt       = clr_r;
    type_nxt      = type_r;
    init_nxt      = init_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      vrra_pkg::ST_INIT: begin
        init_nxt = init_r + ADDR_W'(1);
      end
      vrra_pkg::ST_IDLE: begin
        if (go) begin
          type_nxt = in_record_type;
          if (wrap) begin
            entry_nxt = '0;
            start_nxt = '0;
            end_nxt   = {8'b0, in_size};
            clr_nxt   = next_r;
          end else begin
            entry_nxt = next_r;
            start_nxt = {1'b0, oldest_r};
            end_nxt   = next_r + {8'b0, in_size};
          end
        end
      end
      vrra_pkg::ST_TAIL: begin
        clr_nxt = clr_r + 15'd1;
      end
      vrra_pkg::ST_WALK_STEP: begin
        if (walk_size == '0) start_nxt = '0;
        else start_nxt = step_sum;
      end
      vrra_pkg::ST_HEAD: begin
        oldest_nxt = (start_r == {1'b0, ring_use}) ? '0 : start_r[PW-1:0];
        next_nxt   = end_r;
        clr_nxt    = entry_r + 15'd1;
      end
      vrra_pkg::ST_BODY: begin
        clr_nxt = clr_r + 15'd1;
      end
      vrra_pkg::ST_OUT: begin
        if (out_load) out_valid_nxt = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= vrra_pkg::ST_INIT;
      oldest_r    <= '0;
      next_r      <= '0;
      init_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      oldest_r    <= oldest_nxt;
      next_r      <= next_nxt;
      init_r      <= init_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    end_r   <= end_nxt;
    start_r <= start_nxt;
    clr_r   <= clr_nxt;
    type_r  <= type_nxt;
    if (state_r == vrra_pkg::ST_OUT && out_load) begin
      out_entry_r  <= entry_r[vrra_pkg::ENTRY_W-1:0];
      out_oldest_r <= oldest_r;
      out_next_r   <= next_r;
    end
  end

  // type memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) type_mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_r <= type_mem[mem_raddr];
  end

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_bytes_r   <= vrra_pkg::RING_BYTES_RESET;
      size_dur_r     <= vrra_pkg::SIZE_DURATION_RESET;
      size_dur_col_r <= vrra_pkg::SIZE_DURATION_COLORED_RESET;
      size_inst_r    <= vrra_pkg::SIZE_INSTANT_RESET;
      size_cnt_r     <= vrra_pkg::SIZE_COUNTER_RESET;
      size_link_r    <= vrra_pkg::SIZE_LINK_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        vrra_pkg::REG_RING_BYTES:            ring_bytes_r   <= cfg_wdata;
        vrra_pkg::REG_SIZE_DURATION:         size_dur_r     <= cfg_wdata[SW-1:0];
        vrra_pkg::REG_SIZE_DURATION_COLORED: size_dur_col_r <= cfg_wdata[SW-1:0];
        vrra_pkg::REG_SIZE_INSTANT:          size_inst_r    <= cfg_wdata[SW-1:0];
        vrra_pkg::REG_SIZE_COUNTER:          size_cnt_r     <= cfg_wdata[SW-1:0];
        vrra_pkg::REG_SIZE_LINK:             size_link_r    <= cfg_wdata[SW-1:0];
        default: begin
        end
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_entry_offset  = out_entry_r;
  assign out_oldest_offset = out_oldest_r;
  assign out_next_offset   = out_next_r;

endmodule

`default_nettype wire

// File: rtl/vrra_checker.sv
// vrra_checker: port-level assertions for the ring allocator core, bound to
// variable_record_ring_allocator_core; uses vrra_pkg
`default_nettype none

module vrra_checker (
  input wire                             clk,
  input wire                             rst_n,
  input wire                             in_valid,
  input wire                             in_stall,
  input wire [vrra_pkg::TYPE_W-1:0]      in_record_type,
  input wire                             out_valid,
  input wire                             out_stall,
  input wire [vrra_pkg::ENTRY_W-1:0]     out_entry_offset,
  input wire [vrra_pkg::PTR_W-1:0]       out_oldest_offset,
  input wire [vrra_pkg::PTR_W-1:0]       out_next_offset
);

  // reset starts the clearing pass with no result pending
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> in_stall && !out_valid)
    else $error("core not stalled or result pending after reset");

  // an accepted known record type keeps the core busy afterwards
  a_known_type_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_record_type != vrra_pkg::REC_EMPTY &&
     in_record_type <= vrra_pkg::REC_LINK) |=> in_stall)
    else $error("core ready right after a known record type");

  // a placed record always ends past its start
  a_next_after_entry: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({1'b0, out_entry_offset} < out_next_offset))
    else $error("next offset not past entry offset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid && $stable(out_entry_offset) &&
    $stable(out_oldest_offset) && $stable(out_next_offset))
    else $error("stalled result changed");

endmodule

bind variable_record_ring_allocator_core vrra_checker u_vrra_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .in_record_type    (in_record_type),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_entry_offset  (out_entry_offset),
  .out_oldest_offset (out_oldest_offset),
  .out_next_offset   (out_next_offset)
);

`default_nettype wire
